// ----- hdl/mexp_pkg.sv -----
// Shared constants for the modular exponentiation core.
package mexp_pkg;

  // Default width of the message, result, modulus and exponent words.
  localparam int DEFAULT_WORD_BITS = 32;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_EXPONENT = 1'b1;

endpackage

// ----- hdl/mexp_mulmod.sv -----
// Bit-serial modular multiplier: p = (a * b) mod n, one bit of b per cycle.
module mexp_mulmod #(
  parameter int WORD_BITS = mexp_pkg::DEFAULT_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] a,
  input  logic [WORD_BITS-1:0] b,
  input  logic [WORD_BITS-1:0] n,
  output logic                 done,
  output logic [WORD_BITS-1:0] p
);

  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [WORD_BITS-1:0] acc_r;
  logic [WORD_BITS-1:0] a_r;
  logic [WORD_BITS-1:0] b_sh_r;

  // One step: acc = (2*acc + bit*a) mod n. The sum stays below 3n, so the
  // result is the sum minus 0, n or 2n, all three tried side by side.
  logic [WORD_BITS+1:0] sum;
  logic [WORD_BITS+2:0] diff1;
  logic [WORD_BITS+2:0] diff2;
  logic [WORD_BITS-1:0] acc_nxt;

  always_comb begin
    sum   = {1'b0, acc_r, 1'b0} + (b_sh_r[WORD_BITS-1] ? {2'b00, a_r} : '0);
    diff1 = {1'b0, sum} - {3'b000, n};
    diff2 = {1'b0, sum} - {2'b00, n, 1'b0};
    if (!diff2[WORD_BITS+2]) begin
      acc_nxt = diff2[WORD_BITS-1:0];
    end else if (!diff1[WORD_BITS+2]) begin
      acc_nxt = diff1[WORD_BITS-1:0];
    end else begin
      acc_nxt = sum[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(WORD_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= '0;
      a_r    <= a;
      b_sh_r <= b;
    end else if (busy_r) begin
      acc_r  <= acc_nxt;
      b_sh_r <= {b_sh_r[WORD_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- hdl/modular_exponentiation_core.sv -----
// One transaction is in work at a time; the rate is set by the bit-serial modular
// multiplier, which retires one multiplier bit per cycle and is shared by every step.
// Reset (synchronous, rst_n low) sets modulus to 2, exponent to 1 and empties the block.
// A finished result waits in the output register while the next message is accepted.
module modular_exponentiation_core #(
  parameter int WORD_BITS = mexp_pkg::DEFAULT_WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]                cfg_wdata,
  // Input channel.
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [WORD_BITS-1:0]                in_message,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [WORD_BITS-1:0]                out_result
);

  localparam int CNT_BITS = $clog2(WORD_BITS + 1);

  // The work is a left-to-right square-and-multiply. The message is first
  // reduced below the modulus by running it through the multiplier as
  // 1 * message mod n. After that each exponent bit, from the top down,
  // costs one squaring and, when the bit is set, one multiply by the base.
  // The degenerate cases (exponent zero, modulus zero or one) finish at once.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_t;

  state_t               state_r;
  logic [WORD_BITS-1:0] modulus_r;
  logic [WORD_BITS-1:0] exponent_r;
  logic [WORD_BITS-1:0] exp_sh_r;
  logic [WORD_BITS-1:0] base_r;
  logic [WORD_BITS-1:0] res_r;
  logic [CNT_BITS-1:0]  bit_cnt_r;
  logic                 mul_start_r;
  logic [WORD_BITS-1:0] mul_a_r;
  logic [WORD_BITS-1:0] mul_b_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_result_r;

  logic                 mul_done;
  logic [WORD_BITS-1:0] mul_p;
  logic                 in_take;
  logic                 out_free;
  logic                 last_bit;

  // Configuration registers. Writes must arrive only while the block is idle; the block itself
  // does not enforce this. The datapath reads them directly during a transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= WORD_BITS'(2);
      exponent_r <= WORD_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus_r  <= cfg_wdata;
        mexp_pkg::REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_start_r),
    .a    (mul_a_r),
    .b    (mul_b_r),
    .n    (modulus_r),
    .done (mul_done),
    .p    (mul_p)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  // The output register can take a new result when it is empty or its
  // current result leaves in this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign last_bit = (bit_cnt_r == CNT_BITS'(1));

  // Sequencer: state, multiplier operands and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            exp_sh_r <= exponent_r;
            if (exponent_r == '0) begin
              // Empty product: one, not reduced.
              res_r   <= WORD_BITS'(1);
              state_r <= ST_FINISH;
            end else if (modulus_r < WORD_BITS'(2)) begin
              res_r   <= '0;
              state_r <= ST_FINISH;
            end else begin
              mul_a_r     <= WORD_BITS'(1);
              mul_b_r     <= in_message;
              mul_start_r <= 1'b1;
              state_r     <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (mul_done) begin
            // The accumulator starts at one; its first squaring opens the loop.
            base_r      <= mul_p;
            bit_cnt_r   <= CNT_BITS'(WORD_BITS);
            mul_a_r     <= WORD_BITS'(1);
            mul_b_r     <= WORD_BITS'(1);
            mul_start_r <= 1'b1;
            state_r     <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          if (mul_done) begin
            if (exp_sh_r[WORD_BITS-1]) begin
              mul_a_r     <= mul_p;
              mul_b_r     <= base_r;
              mul_start_r <= 1'b1;
              state_r     <= ST_MULT;
            end else begin
              exp_sh_r <= {exp_sh_r[WORD_BITS-2:0], 1'b0};
              if (last_bit) begin
                res_r   <= mul_p;
                state_r <= ST_FINISH;
              end else begin
                bit_cnt_r   <= bit_cnt_r - 1'b1;
                mul_a_r     <= mul_p;
                mul_b_r     <= mul_p;
                mul_start_r <= 1'b1;
              end
            end
          end
        end
        ST_MULT: begin
          if (mul_done) begin
            exp_sh_r <= {exp_sh_r[WORD_BITS-2:0], 1'b0};
            if (last_bit) begin
              res_r   <= mul_p;
              state_r <= ST_FINISH;
            end else begin
              bit_cnt_r   <= bit_cnt_r - 1'b1;
              mul_a_r     <= mul_p;
              mul_b_r     <= mul_p;
              mul_start_r <= 1'b1;
              state_r     <= ST_SQUARE;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_result_r <= res_r;
            out_valid_r  <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- hdl/mexp_checker.sv -----
// Port-level checks for the modular exponentiation core, bound to the top level.
module mexp_checker #(
  parameter int WORD_BITS = mexp_pkg::DEFAULT_WORD_BITS
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_BITS-1:0] out_result
);

  // An accepted transaction keeps the input side closed in the next cycle.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input accepted again right after a transaction");

  // A new result only appears while a transaction was in work.
  a_result_from_work: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result appeared with no transaction in work");

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_result))
  ) else $error("stalled result changed or dropped");

  // Reset leaves no result on the output.
  a_reset_empty: assert property (
    @(posedge clk)
    !rst_n |=> !out_valid
  ) else $error("result valid right after reset");

endmodule

bind modular_exponentiation_core mexp_checker #(
  .WORD_BITS(WORD_BITS)
) u_mexp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_result(out_result)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for modular_exponentiation_core: directed keys, RSA round trip, random keys.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = mexp_pkg::DEFAULT_WORD_BITS;

  // The clock, reset and every input of the core start at a known value.
  logic                                clk        = 1'b0;
  logic                                rst_n      = 1'b0;
  logic                                cfg_we     = 1'b0;
  logic [mexp_pkg::CFG_INDEX_BITS-1:0] cfg_index  = mexp_pkg::REG_MODULUS;
  logic [W-1:0]                        cfg_wdata  = '0;
  logic                                in_valid   = 1'b0;
  logic                                in_stall;
  logic [W-1:0]                        in_message = '0;
  logic                                out_valid;
  logic                                out_stall  = 1'b0;
  logic [W-1:0]                        out_result;

  // Messages waiting to be offered, and results owed by the core, oldest first.
  logic [W-1:0] message_queue [$];
  logic [W-1:0] expected_results [$];

  // Shadow copy of the key registers; they come out of reset as modulus 2, exponent 1.
  logic [W-1:0] key_modulus  = W'(2);
  logic [W-1:0] key_exponent = W'(1);

  int messages_accepted = 0;
  int results_checked   = 0;
  int keys_loaded       = 0;
  int mismatches        = 0;
  int errors            = 0;

  modular_exponentiation_core #(
    .WORD_BITS(W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_message(in_message),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result)
  );

  // 4 ns period clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes base to the power exponent, reduced by the modulus, with left-to-right
  // square-and-multiply. Operands stay below the modulus, so every product fits in
  // twice the word width. A zero exponent gives the empty product 1 even when the
  // modulus is zero or one; a zero modulus with a nonzero exponent gives 0.
  function automatic logic [W-1:0] mod_power(input logic [W-1:0] base,
                                             input logic [W-1:0] power,
                                             input logic [W-1:0] modulus);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] reduced_base;
    if (power == '0) return W'(1);
    if (modulus == '0) return '0;
    reduced_base = base % modulus;
    acc = (2*W)'(1) % modulus;
    for (int i = W - 1; i >= 0; i--) begin
      acc = (acc * acc) % modulus;
      if (power[i]) begin
        acc = (acc * reduced_base) % modulus;
      end
    end
    return acc[W-1:0];
  endfunction

  // Driver. When a transaction is taken at this edge, the expected result is predicted
  // from the key in force; the key only changes while the core is idle, so this is the
  // key the core uses too. A new message is offered only once the previous one is gone,
  // so a stalled payload never changes. Between the 100th and 160th accepted message
  // the sender never idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(mod_power(in_message, key_exponent, key_modulus));
        messages_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (message_queue.size() != 0 &&
            ((messages_accepted >= 100 && messages_accepted < 160) ||
             $urandom_range(0, 99) >= 36)) begin
          in_valid   <= 1'b1;
          in_message <= message_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every transaction on the result channel is matched against the oldest
  // expected result. The receiver stalls at random, except for a window of results
  // where it takes everything at once.
  always @(posedge clk) begin : result_monitor
    logic [W-1:0] wanted;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !(results_checked >= 100 && results_checked < 160) &&
                   ($urandom_range(0, 99) < 36);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result 0x%08h with nothing outstanding", out_result);
          end
        end else begin
          wanted = expected_results.pop_front();
          if (out_result !== wanted) begin
            errors++;
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result mismatch on transaction %0d: expected 0x%08h, got 0x%08h",
                       results_checked, wanted, out_result);
            end
          end
        end
      end
    end
  end

  // Returns once the core holds no work: every queued message has been taken and every
  // expected result has come back. Conditions are sampled on the falling edge, away from
  // the edge at which the driver and the monitor update them.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (message_queue.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Writes one key register; the core takes it at the next rising edge.
  task automatic write_register(input logic [mexp_pkg::CFG_INDEX_BITS-1:0] index,
                                input logic [W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    if (index == mexp_pkg::REG_MODULUS) begin
      key_modulus = value;
    end else begin
      key_exponent = value;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Loads a new key. The sender first holds off until every result under the old key
  // has come back, so the registers never change under a message in flight.
  task automatic load_key(input logic [W-1:0] modulus, input logic [W-1:0] power);
    wait_idle();
    write_register(mexp_pkg::REG_MODULUS, modulus);
    write_register(mexp_pkg::REG_EXPONENT, power);
    keys_loaded++;
  endtask

  // Stimulus: a directed part that covers the reset key, the word extremes, the special
  // cases of a zero exponent and of moduli zero and one, and a small RSA key pair used
  // for encryption and then decryption; then random keys with random messages.
  initial begin : stimulus
    logic [W-1:0] plain [5];
    logic [W-1:0] modulus;
    logic [W-1:0] power;
    logic [W-1:0] word;
    int           random_sent;
    int           burst;

    random_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset key: modulus 2, exponent 1, so the result is the parity of the message.
    message_queue.push_back('0);
    message_queue.push_back('1);
    message_queue.push_back(W'(1));
    message_queue.push_back(W'(2));
    message_queue.push_back(W'(3));

    // Largest modulus and largest exponent: the longest run of multiplies.
    load_key('1, '1);
    message_queue.push_back('0);
    message_queue.push_back('1);
    message_queue.push_back('1 - W'(1));
    message_queue.push_back(W'(1) << (W - 1));
    message_queue.push_back(W'(1));

    // Zero exponent gives 1, even with modulus zero.
    load_key('0, '0);
    message_queue.push_back('0);
    message_queue.push_back('1);

    // Modulus zero with a nonzero exponent, then modulus one: both give 0.
    load_key('0, W'(5));
    message_queue.push_back(W'(7));
    load_key(W'(1), W'(3));
    message_queue.push_back(W'(9));

    // Encryption with the public key (3233, 17), including messages at and above the
    // modulus, then decryption of the ciphertexts with the private exponent 2753.
    plain = '{W'(65), W'(123), W'(3232), W'(3233), W'(32'hDEADBEEF)};
    load_key(W'(3233), W'(17));
    foreach (plain[i]) message_queue.push_back(plain[i]);
    load_key(W'(3233), W'(2753));
    foreach (plain[i]) message_queue.push_back(mod_power(plain[i], W'(17), W'(3233)));

    // Random keys. Each key mixes extreme and ordinary values, and each burst of messages
    // mixes the word extremes, values next to the modulus and fully random words.
    while (random_sent < 250) begin
      case ($urandom_range(0, 9))
        0:       modulus = W'($urandom_range(0, 2));
        1:       modulus = '1;
        2:       modulus = W'($urandom_range(3, 1000));
        3:       modulus = W'($urandom) | (W'(1) << (W - 1));
        default: modulus = W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       power = '0;
        1:       power = '1;
        2:       power = W'($urandom_range(1, 20));
        3:       power = W'(65537);
        default: power = W'($urandom);
      endcase
      load_key(modulus, power);
      burst = $urandom_range(6, 20);
      repeat (burst) begin
        case ($urandom_range(0, 9))
          0:       word = '0;
          1:       word = '1;
          2:       word = modulus - W'(1);
          3:       word = modulus;
          4:       word = (modulus != '0) ? W'($urandom) % modulus : W'($urandom);
          default: word = W'($urandom);
        endcase
        message_queue.push_back(word);
        random_sent++;
      end
    end

    // Drain, then watch long enough for one more full exponentiation so that a stray
    // extra result would still be caught.
    wait_idle();
    repeat (2300) @(posedge clk);
    @(negedge clk);
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end

    $display("Ran %0d messages under %0d loaded keys plus the reset key; %0d results checked.",
             messages_accepted, keys_loaded, results_checked);
    $display("%0d mismatching or unexpected results in total.", mismatches);
    if (errors == 0) begin
      $display("[modular_exponentiation_core] OK");
    end else begin
      $display("[modular_exponentiation_core] ERROR");
    end
    $finish;
  end

  // Watchdog: many times the slowest legal run of all messages at the longest latency.
  initial begin
    #30_000_000;
    $display("Timed out with %0d results still expected", expected_results.size());
    $display("[modular_exponentiation_core] ERROR");
    $finish;
  end

endmodule
